>>> src/asbf_pkg.sv
package asbf_pkg;

   // default configuration and limits
   localparam int MAX_PAYLOAD_LEN_DEF = 31;
   localparam int BYTE_W              = 8;
   localparam int PATTERN_W           = 24;
   localparam int NSS_W               = 9;
   localparam int CSR_IDX_W           = 1;
   localparam int CSR_DATA_W          = PATTERN_W;

   localparam logic [BYTE_W-1:0]    WANTED_TYPE_RST    = 8'hFF;
   localparam logic [PATTERN_W-1:0] FILTER_PATTERN_RST = 24'h02004C;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WANTED_TYPE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_PATTERN = 1'd1;

   // parse phases
   localparam logic [1:0] PH_SCAN = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_CMP  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0]    wanted_type;
      logic [PATTERN_W-1:0] filter_pattern;
   } cfg_type;

   typedef struct packed {
      logic type_found;
      logic pattern_match;
   } result_type;

endpackage

>>> src/asbf_if.sv
interface asbf_req_if;
   logic                        valid;
   logic                        ready;
   logic [asbf_pkg::BYTE_W-1:0] data_byte;
   logic                        last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface asbf_rsp_if;
   logic valid;
   logic ready;
   logic type_found;
   logic pattern_match;

   modport source (output valid, output type_found, output pattern_match, input ready);
   modport sink   (input valid, input type_found, input pattern_match, output ready);
endinterface

>>> src/asbf_csr.sv
module asbf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [asbf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [asbf_pkg::CSR_DATA_W-1:0]     csr_data,
   output asbf_pkg::cfg_type                   cfg
);

   asbf_pkg::cfg_type cfg_ff;
   asbf_pkg::cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            asbf_pkg::CSR_WANTED_TYPE:
               cfg_in.wanted_type = csr_data[asbf_pkg::BYTE_W-1:0];
            asbf_pkg::CSR_FILTER_PATTERN:
               cfg_in.filter_pattern = csr_data[asbf_pkg::PATTERN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wanted_type    <= asbf_pkg::WANTED_TYPE_RST;
         cfg_ff.filter_pattern <= asbf_pkg::FILTER_PATTERN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/asbf_parse.sv
module asbf_parse #(
   parameter int MAX_PAYLOAD_LEN = asbf_pkg::MAX_PAYLOAD_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [asbf_pkg::BYTE_W-1:0] data_byte,
   input  logic                        last_byte,
   input  asbf_pkg::cfg_type           cfg,
   output asbf_pkg::result_type        result
);

   localparam int POS_W = $clog2(MAX_PAYLOAD_LEN + 1);
   localparam int NW    = asbf_pkg::NSS_W;

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [NW-1:0]    nss_ff,   nss_in;
   logic [1:0]       phase_ff, phase_in;
   logic             found_ff, found_in;
   logic [1:0]       count_ff, count_in;
   logic             match_ff, match_in;

   logic [POS_W-1:0] pos_n;
   logic [NW-1:0]    nss_n;
   logic [1:0]       phase_n;
   logic             found_n;
   logic [1:0]       count_n;
   logic             match_n;

   logic [NW-1:0]               pos_ext;
   logic                        long_enough;
   logic [asbf_pkg::BYTE_W-1:0] want;

   assign pos_ext     = NW'(pos_ff);
   assign long_enough = {1'b0, nss_ff} >= ({1'b0, pos_ext} + (NW+1)'(2));

   // pick the pattern byte for this compare step
   always_comb begin
      case (count_ff)
         2'd0:    want = cfg.filter_pattern[7:0];
         2'd1:    want = cfg.filter_pattern[15:8];
         2'd2:    want = cfg.filter_pattern[23:16];
         default: want = '0;
      endcase
   end

   // walk the structure chain for one byte
   always_comb begin
      pos_n   = pos_ff;
      nss_n   = nss_ff;
      phase_n = phase_ff;
      found_n = found_ff;
      count_n = count_ff;
      match_n = match_ff;
      if (pos_ff < POS_W'(MAX_PAYLOAD_LEN)) begin
         if ((phase_ff == asbf_pkg::PH_SCAN || phase_ff == asbf_pkg::PH_TYPE) &&
             pos_ext == nss_ff) begin
            nss_n   = pos_ext + NW'(data_byte) + NW'(1);
            phase_n = asbf_pkg::PH_TYPE;
         end else if (phase_ff == asbf_pkg::PH_TYPE) begin
            if (data_byte == cfg.wanted_type && long_enough) begin
               found_n = 1'b1;
               count_n = 2'd0;
               match_n = 1'b1;
               phase_n = asbf_pkg::PH_CMP;
            end else begin
               phase_n = asbf_pkg::PH_SCAN;
            end
         end else if (phase_ff == asbf_pkg::PH_CMP) begin
            if (data_byte != want) match_n = 1'b0;
            if (count_ff >= 2'd2) phase_n = asbf_pkg::PH_DONE;
            else                  count_n = count_ff + 2'd1;
         end
         pos_n = pos_ff + POS_W'(1);
      end
   end

   // report on the last byte
   assign result.type_found    = found_n;
   assign result.pattern_match = found_n && (phase_n == asbf_pkg::PH_DONE) && match_n;

   // commit, or clear at the end of a packet
   always_comb begin
      pos_in   = pos_ff;
      nss_in   = nss_ff;
      phase_in = phase_ff;
      found_in = found_ff;
      count_in = count_ff;
      match_in = match_ff;
      if (fire) begin
         if (last_byte) begin
            pos_in   = '0;
            nss_in   = '0;
            phase_in = asbf_pkg::PH_SCAN;
            found_in = 1'b0;
            count_in = 2'd0;
            match_in = 1'b1;
         end else begin
            pos_in   = pos_n;
            nss_in   = nss_n;
            phase_in = phase_n;
            found_in = found_n;
            count_in = count_n;
            match_in = match_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         nss_ff   <= '0;
         phase_ff <= asbf_pkg::PH_SCAN;
         found_ff <= 1'b0;
         count_ff <= 2'd0;
         match_ff <= 1'b1;
      end else begin
         pos_ff   <= pos_in;
         nss_ff   <= nss_in;
         phase_ff <= phase_in;
         found_ff <= found_in;
         count_ff <= count_in;
         match_ff <= match_in;
      end
   end

endmodule

>>> src/adv_structure_beacon_filter_unit.sv
// Advertising structure filter.
// req_chan carries one payload byte per item with a last-byte mark. The
// block walks the length-type-data chain, locks on the first structure of
// the wanted type with a length byte of at least 2, and compares the three
// bytes after its type byte with the pattern.
// rsp_chan carries one item per packet, produced by the last byte, with
// type_found and pattern_match.
// csr_write / csr_index / csr_data set wanted_type (index 0) and
// filter_pattern (index 1); write only while no packet is in flight.
// Throughput: one byte per cycle, unless a last byte waits on a full result.
// Each byte passes the input register, then one update of the parse state
// registers, which also loads the result register.
// Reset clears the parse state and both registers and restores the default
// configuration (type 0xFF, pattern 0x02004C).
// When rsp_chan stalls, bytes without the last mark keep flowing; a last
// byte waits in the input register until the result register frees up.
module adv_structure_beacon_filter_unit #(
   parameter int MAX_PAYLOAD_LEN = asbf_pkg::MAX_PAYLOAD_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   asbf_req_if.sink                        req_chan,
   asbf_rsp_if.source                      rsp_chan,
   input  logic                            csr_write,
   input  logic [asbf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [asbf_pkg::CSR_DATA_W-1:0] csr_data
);

   asbf_pkg::cfg_type    cfg;
   asbf_pkg::result_type result;

   logic                        s1_valid_ff, s1_valid_in;
   logic [asbf_pkg::BYTE_W-1:0] s1_byte_ff;
   logic                        s1_last_ff;
   logic                        out_valid_ff, out_valid_in;
   asbf_pkg::result_type        out_ff;
   logic                        out_free;
   logic                        s1_fire;
   logic                        req_take;

   asbf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   asbf_parse #(.MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN)) u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .cfg       (cfg),
      .result    (result)
   );

   // advance the input register unless a last byte meets a full result
   assign out_free        = !out_valid_ff || rsp_chan.ready;
   assign s1_fire         = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_chan.ready  = !s1_valid_ff || s1_fire;
   assign req_take        = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_chan.ready) s1_valid_in = req_chan.valid;
   end

   // load the result register on a last byte, drop it once taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_fire && s1_last_ff) out_valid_in = 1'b1;
      else if (rsp_chan.ready)   out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
      if (s1_fire && s1_last_ff) out_ff <= result;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.type_found    = out_ff.type_found;
   assign rsp_chan.pattern_match = out_ff.pattern_match;

endmodule

>>> src/asbf_check.sv
module asbf_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_type_found,
   input logic rsp_pattern_match
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a match always comes with a found structure
   a_match_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_pattern_match || rsp_type_found))
      else $error("pattern_match without type_found");

   // a stalled result holds its flags
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_type_found) && $stable(rsp_pattern_match))
      else $error("stalled result changed");

   // a free input register always takes an item
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !rsp_valid && !$past(req_valid) |-> req_ready)
      else $error("input stalled while nothing is pending");

endmodule

bind adv_structure_beacon_filter_unit asbf_check u_asbf_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_type_found    (rsp_chan.type_found),
   .rsp_pattern_match (rsp_chan.pattern_match)
);

>>> sim/asbf_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts the result of every
// packet and compares it with what the block returns.
module asbf_checker
   import asbf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_data_byte,
   input  logic                  req_last_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_type_found,
   input  logic                  rsp_pattern_match,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   cfg_type          cfg;
   logic [7:0]       pos;
   logic [NSS_W-1:0] struct_end;
   logic [1:0]       phase;
   logic             locked;
   logic [1:0]       cmp_idx;
   logic             cmp_ok;
   result_type       expected_verdicts[$];
   int               errs = 0;

   // return the structure walk to the start of a packet
   task automatic restart_walk();
      pos        = '0;
      struct_end = '0;
      phase      = PH_SCAN;
      locked     = 1'b0;
      cmp_idx    = '0;
      cmp_ok     = 1'b1;
   endtask

   // advance the walk by one payload byte
   task automatic feed_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] want;
      if (int'(pos) >= MAX_PAYLOAD_LEN_DEF) return;
      if ((phase == PH_SCAN || phase == PH_TYPE) && int'(struct_end) == int'(pos)) begin
         // length byte: note where the next structure starts
         struct_end = NSS_W'(int'(pos) + int'(b) + 1);
         phase      = PH_TYPE;
      end else if (phase == PH_TYPE) begin
         // type byte: lock only with at least one data byte in the structure
         if (b == cfg.wanted_type && int'(struct_end) >= int'(pos) + 2) begin
            locked  = 1'b1;
            cmp_idx = '0;
            cmp_ok  = 1'b1;
            phase   = PH_CMP;
         end else begin
            phase = PH_SCAN;
         end
      end else if (phase == PH_CMP) begin
         want = cfg.filter_pattern[8*cmp_idx +: 8];
         if (b != want) cmp_ok = 1'b0;
         if (cmp_idx >= 2'd2) phase = PH_DONE;
         else cmp_idx = cmp_idx + 2'd1;
      end
      pos = pos + 8'd1;
   endtask

   always @(posedge clock) begin
      result_type verdict;
      result_type want;
      if (reset) begin
         cfg.wanted_type    = WANTED_TYPE_RST;
         cfg.filter_pattern = FILTER_PATTERN_RST;
         restart_walk();
         expected_verdicts.delete();
      end else begin
         // track register writes
         if (csr_write) begin
            if (csr_index == CSR_WANTED_TYPE) cfg.wanted_type = csr_data[BYTE_W-1:0];
            else if (csr_index == CSR_FILTER_PATTERN) cfg.filter_pattern = csr_data;
         end
         // predict on every accepted byte
         if (req_valid && req_ready) begin
            feed_byte(req_data_byte);
            if (req_last_byte) begin
               verdict.type_found    = locked;
               verdict.pattern_match = locked && phase == PH_DONE && cmp_ok;
               expected_verdicts.push_back(verdict);
               restart_walk();
            end
         end
         // compare every accepted result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result: type_found=%0b pattern_match=%0b",
                      rsp_type_found, rsp_pattern_match);
               errs++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_type_found !== want.type_found) begin
                  $error("type_found: expected %0b, actual %0b",
                         want.type_found, rsp_type_found);
                  errs++;
               end
               if (rsp_pattern_match !== want.pattern_match) begin
                  $error("pattern_match: expected %0b, actual %0b",
                         want.pattern_match, rsp_pattern_match);
                  errs++;
               end
            end
         end
      end
      fail_count <= errs;
      pending    <= expected_verdicts.size();
   end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import asbf_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 450;
   localparam int PHASE_ITEMS  = 75;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WANTED_TYPE;
   logic [CSR_DATA_W-1:0] csr_data  = '0;
   logic                  rsp_ready_q = 1'b0;
   logic                  rsp_quiet   = 1'b0;
   logic                  req_quiet   = 1'b0;
   int                    rsp_hold    = 0;
   int                    cycles      = 0;
   int                    fail_count;
   int                    pending;
   int                    random_sent = 0;
   logic [BYTE_W-1:0]     cur_type    = WANTED_TYPE_RST;
   logic [PATTERN_W-1:0]  cur_pattern = FILTER_PATTERN_RST;
   logic [BYTE_W-1:0]     payload_q[$];

   asbf_req_if req_chan();
   asbf_rsp_if rsp_chan();

   assign rsp_chan.ready = rsp_ready_q;

   adv_structure_beacon_filter_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   asbf_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_data_byte     (req_chan.data_byte),
      .req_last_byte     (req_chan.last_byte),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_type_found    (rsp_chan.type_found),
      .rsp_pattern_match (rsp_chan.pattern_match),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always #5 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // stall the result side for a random number of cycles after each item
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_ready_q <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 11);
         else if (rsp_hold > 0) rsp_hold--;
         rsp_ready_q <= (rsp_hold == 0);
      end
   end

   // offer one byte after a random gap and hold it until taken
   task automatic send_item(input logic [BYTE_W-1:0] b, input logic last);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_payload();
      for (int i = 0; i < payload_q.size(); i++)
         send_item(payload_q[i], i == payload_q.size() - 1);
   endtask

   // hold the sender until every packet result is back, then let the block settle
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both registers on consecutive edges; only call while idle
   task automatic set_config(input logic [BYTE_W-1:0] t, input logic [PATTERN_W-1:0] p);
      csr_write <= 1'b1;
      csr_index <= CSR_WANTED_TYPE;
      csr_data  <= {16'($urandom_range(0, 65535)), t};
      @(posedge clock);
      csr_index <= CSR_FILTER_PATTERN;
      csr_data  <= p;
      @(posedge clock);
      csr_write   <= 1'b0;
      cur_type    = t;
      cur_pattern = p;
   endtask

   // build one random packet: mostly well-formed structure chains
   task automatic make_payload();
      int                kind;
      int                nstruct;
      int                len;
      int                cut;
      logic              use_pat;
      logic [BYTE_W-1:0] b;
      payload_q.delete();
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
         // plain noise
         repeat ($urandom_range(1, 12)) payload_q.push_back(8'($urandom));
      end else begin
         nstruct = $urandom_range(1, 4);
         repeat (nstruct) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            payload_q.push_back(8'(len));
            if (len > 0) begin
               payload_q.push_back($urandom_range(0, 1) ? cur_type : 8'($urandom));
               use_pat = ($urandom_range(0, 2) != 0);
               for (int j = 1; j < len; j++) begin
                  if (use_pat && j <= 3) begin
                     b = cur_pattern[8*(j-1) +: 8];
                     if ($urandom_range(0, 5) == 0) b ^= 8'(1 << $urandom_range(0, 7));
                  end else begin
                     b = 8'($urandom);
                  end
                  payload_q.push_back(b);
               end
            end
         end
         // break the chain by cutting the packet short
         if (kind == 1) begin
            cut = $urandom_range(1, payload_q.size());
            while (payload_q.size() > cut) void'(payload_q.pop_back());
         end
         // run past the payload limit
         if (kind == 2) begin
            cut = $urandom_range(32, 40);
            while (payload_q.size() < cut) payload_q.push_back(8'($urandom));
         end
      end
   endtask

   task automatic load_bytes(input logic [BYTE_W-1:0] bytes[]);
      payload_q.delete();
      foreach (bytes[i]) payload_q.push_back(bytes[i]);
   endtask

   initial begin
      int                   phase_sent;
      logic [BYTE_W-1:0]    t;
      logic [PATTERN_W-1:0] p;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed packets with the reset configuration
      // full match on the wanted type
      load_bytes('{8'h04, 8'hFF, 8'h4C, 8'h00, 8'h02});
      send_payload();
      // empty structure, then a short one that ends the packet mid-compare
      load_bytes('{8'h00, 8'h02, 8'hFF, 8'h4C});
      send_payload();
      // length one does not qualify; the next structure locks but its one data byte mismatches
      load_bytes('{8'h01, 8'hFF, 8'h02, 8'hFF, 8'h00});
      send_payload();
      // single-byte packet, nothing found
      load_bytes('{8'hFF});
      send_payload();
      // other type first, then a wrong third byte
      load_bytes('{8'h02, 8'hAA, 8'h00, 8'h04, 8'hFF, 8'h4C, 8'h00, 8'h03});
      send_payload();

      // random phases; the first three use the extremes and the default
      for (int ph = 0; random_sent < RANDOM_ITEMS; ph++) begin
         drain();
         case (ph)
            0:       begin t = 8'h00; p = 24'h000000; end
            1:       begin t = 8'hFF; p = 24'hFFFFFF; end
            2:       begin t = WANTED_TYPE_RST; p = FILTER_PATTERN_RST; end
            default: begin t = 8'($urandom); p = 24'($urandom); end
         endcase
         set_config(t, p);
         rsp_quiet <= ($urandom_range(0, 3) == 0);
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS && random_sent < RANDOM_ITEMS) begin
            req_quiet = ($urandom_range(0, 4) == 0);
            make_payload();
            send_payload();
            phase_sent  += payload_q.size();
            random_sent += payload_q.size();
            // pause the sender until the block has caught up
            if (ph == 1 && phase_sent < 20) drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
